/* design/laoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laoa_pkg
// Shared constants and the command and status bundles that join the
// allocator controller to its datapath.
// ----------------------------------------------------------------------------
package laoa_pkg;

	// Width of a byte offset in the arena.
	localparam int OFF_W = 30;

	// Request codes carried by the operation field.
	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_PLACE = 1'b1;

	// Commands from the controller to the datapath, at most one per cycle.
	typedef struct packed {
		logic accept;     // capture the incoming item
		logic clear;      // empty the table, result is zero
		logic walk_start; // reset the search and read the list head
		logic walk_step;  // evaluate the entry just read during the search
		logic loc_start;  // read the entry after the insertion anchor
		logic loc_step;   // evaluate the entry just read while locating
		logic finish;     // latch the full flag for the result
		logic ins_write;  // write the new entry into the free slot
		logic ins_link;   // link the anchor to the new entry
		logic out_load;   // move the result into the output register
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_place;  // captured item is a place request
		logic empty;      // table holds no entries
		logic full;       // table holds MAX_BUFFERS entries
		logic walk_last;  // search ends with the entry now evaluated
		logic loc_none;   // no entry left after the insertion anchor
		logic loc_last;   // locating ends with the entry now evaluated
	} ctl_sts_t;

endpackage

/* design/lifetime_aware_offset_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifetime_aware_offset_allocator
// Places buffers in an arena by lifetime overlap, first fit in offset order.
// ----------------------------------------------------------------------------
// The input channel (in_valid / in_ready) carries one request per item:
// operation 0 empties the table, operation 1 places a buffer with the given
// lifetime and size. The output channel (out_valid / out_ready) returns one
// item per request with the chosen offset and the table_full flag.
// A clear is accepted, empties the table in the decide state and goes to the
// output register. A place runs a first-fit search that visits V entries (at
// most the entry count), then steps over L entries to find the insertion
// point after equal offsets, and writes the new entry unless the table is
// full; both walks follow the offset-ordered link list through the entry
// memory at one entry per cycle.
// One item is worked on at a time; the next one can be accepted in the cycle
// after the result is loaded, even while that result still waits in the
// output register. A stalled receiver holds the block only when the
// following result is ready to be handed over.
// Reset empties the table at once; entry storage needs no clearing pass.
// ----------------------------------------------------------------------------
module lifetime_aware_offset_allocator #(
	parameter int MAX_BUFFERS = 64,
	parameter int STEP_BITS = 10,
	parameter int SIZE_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic [STEP_BITS-1:0]       first_use,
	input  logic [STEP_BITS-1:0]       last_use,
	input  logic [SIZE_BITS-1:0]       buffer_size,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [laoa_pkg::OFF_W-1:0] placed_offset,
	output logic                       table_full
);

	laoa_pkg::ctl_cmd_t cmd;
	laoa_pkg::ctl_sts_t sts;

	laoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	laoa_dp #(
		.MAX_BUFFERS (MAX_BUFFERS),
		.STEP_BITS   (STEP_BITS),
		.SIZE_BITS   (SIZE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.first_use     (first_use),
		.last_use      (last_use),
		.buffer_size   (buffer_size),
		.placed_offset (placed_offset),
		.table_full    (table_full)
	);

	// Only one item is in flight: acceptance closes the input until it is done.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	// A full table is never written.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_write |-> !sts.full)
		else $error("entry written into a full table");

	// The link update always follows the entry write.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_link |-> $past(cmd.ins_write))
		else $error("link update without entry write");

	// The search never overlaps a table update.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_step || cmd.loc_step) |-> !(cmd.ins_write || cmd.clear))
		else $error("table changed during a walk");

endmodule

/* design/laoa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laoa_dp
// Datapath of the offset allocator: the entry table as a linked list in
// offset order, the search and insertion registers, and the result.
// ----------------------------------------------------------------------------
module laoa_dp #(
	parameter int MAX_BUFFERS = 64,
	parameter int STEP_BITS = 10,
	parameter int SIZE_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  laoa_pkg::ctl_cmd_t         cmd,
	output laoa_pkg::ctl_sts_t         sts,
	input  logic                       operation,
	input  logic [STEP_BITS-1:0]       first_use,
	input  logic [STEP_BITS-1:0]       last_use,
	input  logic [SIZE_BITS-1:0]       buffer_size,
	output logic [laoa_pkg::OFF_W-1:0] placed_offset,
	output logic                       table_full
);

	localparam int OFF_W = laoa_pkg::OFF_W;
	localparam int IDX_W = $clog2(MAX_BUFFERS);
	localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
	localparam int ENT_W = 2 * STEP_BITS + OFF_W + SIZE_BITS;
	localparam int CMP_W = (SIZE_BITS > OFF_W) ? SIZE_BITS : OFF_W;
	localparam int SUM_W = CMP_W + 1;

	// Entry layout: {first, last, offset, size}.
	localparam int SIZE_LO = 0;
	localparam int OFF_LO = SIZE_BITS;
	localparam int LAST_LO = SIZE_BITS + OFF_W;
	localparam int FIRST_LO = SIZE_BITS + OFF_W + STEP_BITS;

	logic [ENT_W-1:0] data_mem [MAX_BUFFERS];
	logic [IDX_W-1:0] next_mem [MAX_BUFFERS];

	logic                 op_q;
	logic [STEP_BITS-1:0] first_q;
	logic [STEP_BITS-1:0] last_q;
	logic [SIZE_BITS-1:0] size_q;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] head_q;
	logic [OFF_W-1:0] cand_q;
	logic [CNT_W-1:0] k_q;
	logic             anchor_valid_q;
	logic [IDX_W-1:0] anchor_q;
	logic [IDX_W-1:0] anchor_next_q;
	logic [CNT_W-1:0] anchor_pos_q;
	logic             full_q;

	logic [ENT_W-1:0] rd_data_q;
	logic [IDX_W-1:0] rd_next_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	logic [OFF_W-1:0] out_off_q;
	logic             out_full_q;

	logic [STEP_BITS-1:0] ent_first;
	logic [STEP_BITS-1:0] ent_last;
	logic [OFF_W-1:0]     ent_off;
	logic [SIZE_BITS-1:0] ent_size;
	logic                 overlap;
	logic [OFF_W-1:0]     gap;
	logic                 fit;
	logic                 stop;
	logic [SUM_W-1:0]     ent_end;
	logic [OFF_W-1:0]     end_sat;
	logic [OFF_W-1:0]     cand_next;
	logic [CNT_W-1:0]     k_inc;
	logic [CNT_W-1:0]     pos_inc;
	logic                 loc_le;
	logic [IDX_W-1:0]     slot;
	logic [IDX_W-1:0]     succ;

	assign ent_first = rd_data_q[FIRST_LO +: STEP_BITS];
	assign ent_last = rd_data_q[LAST_LO +: STEP_BITS];
	assign ent_off = rd_data_q[OFF_LO +: OFF_W];
	assign ent_size = rd_data_q[SIZE_LO +: SIZE_BITS];

	// An entry with a reversed lifetime is taken as it stands.
	assign overlap = !((ent_first > last_q) || (first_q > ent_last));
	assign gap = ent_off - cand_q;
	assign fit = (ent_off >= cand_q) && (CMP_W'(gap) >= CMP_W'(size_q));
	assign stop = overlap && fit;
	assign ent_end = SUM_W'(ent_off) + SUM_W'(ent_size);
	assign end_sat = (ent_end > SUM_W'({OFF_W{1'b1}})) ? {OFF_W{1'b1}}
		: ent_end[OFF_W-1:0];

	always_comb begin
		cand_next = cand_q;
		if (overlap && !fit && (end_sat > cand_q)) begin
			cand_next = end_sat;
		end
	end

	assign k_inc = k_q + CNT_W'(1);
	assign pos_inc = anchor_pos_q + CNT_W'(1);
	assign loc_le = ent_off <= cand_q;
	assign slot = count_q[IDX_W-1:0];
	assign succ = anchor_valid_q ? anchor_next_q : head_q;

	assign sts.req_place = op_q;
	assign sts.empty = count_q == '0;
	assign sts.full = count_q == CNT_W'(MAX_BUFFERS);
	assign sts.walk_last = stop || (k_inc == count_q);
	assign sts.loc_none = anchor_pos_q == count_q;
	assign sts.loc_last = !loc_le || (pos_inc == count_q);

	// One read per cycle; the next address comes straight from the link just read.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = head_q;
		if (cmd.walk_start && (count_q != '0)) begin
			rd_en = 1'b1;
			rd_addr = head_q;
		end else if (cmd.walk_step && !stop && (k_inc != count_q)) begin
			rd_en = 1'b1;
			rd_addr = rd_next_q;
		end else if (cmd.loc_start) begin
			rd_en = 1'b1;
			rd_addr = succ;
		end else if (cmd.loc_step && loc_le && (pos_inc != count_q)) begin
			rd_en = 1'b1;
			rd_addr = rd_next_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= data_mem[rd_addr];
			rd_next_q <= next_mem[rd_addr];
		end
		if (cmd.ins_write) begin
			data_mem[slot] <= {first_q, last_q, cand_q, size_q};
			next_mem[slot] <= succ;
		end else if (cmd.ins_link && anchor_valid_q) begin
			next_mem[anchor_q] <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.ins_link) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= operation;
			first_q <= first_use;
			last_q <= last_use;
			size_q <= buffer_size;
		end
		if (rd_en) begin
			rd_ptr_q <= rd_addr;
		end
		if (cmd.clear) begin
			cand_q <= '0;
			full_q <= 1'b0;
		end
		if (cmd.walk_start) begin
			cand_q <= '0;
			k_q <= '0;
			anchor_valid_q <= 1'b0;
			anchor_pos_q <= '0;
		end
		// The anchor is the last entry known to sit at or below the final offset.
		if (cmd.walk_step) begin
			cand_q <= cand_next;
			k_q <= k_inc;
			if (ent_off <= cand_next) begin
				anchor_valid_q <= 1'b1;
				anchor_q <= rd_ptr_q;
				anchor_next_q <= rd_next_q;
				anchor_pos_q <= k_inc;
			end
		end
		if (cmd.loc_step && loc_le) begin
			anchor_valid_q <= 1'b1;
			anchor_q <= rd_ptr_q;
			anchor_next_q <= rd_next_q;
			anchor_pos_q <= pos_inc;
		end
		if (cmd.finish) begin
			full_q <= sts.full;
		end
		if (cmd.ins_write && !anchor_valid_q) begin
			head_q <= slot;
		end
		if (cmd.out_load) begin
			out_off_q <= cand_q;
			out_full_q <= full_q;
		end
	end

	assign placed_offset = out_off_q;
	assign table_full = out_full_q;

endmodule

/* design/laoa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laoa_ctrl
// Sequencer of the offset allocator: steps the datapath through the search,
// the insertion point lookup, the table update and the result handoff.
// ----------------------------------------------------------------------------
module laoa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output laoa_pkg::ctl_cmd_t cmd,
	input  laoa_pkg::ctl_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WALK_RD,
		ST_WALK,
		ST_LOC_RD,
		ST_LOC,
		ST_FINISH,
		ST_INSERT,
		ST_LINK,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;

	always_comb begin
		cmd = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.req_place) begin
					state_nx = ST_WALK_RD;
				end else begin
					cmd.clear = 1'b1;
					state_nx = ST_RESP;
				end
			end
			ST_WALK_RD: begin
				cmd.walk_start = 1'b1;
				state_nx = sts.empty ? ST_LOC_RD : ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_nx = ST_LOC_RD;
				end
			end
			ST_LOC_RD: begin
				if (sts.loc_none) begin
					state_nx = ST_FINISH;
				end else begin
					cmd.loc_start = 1'b1;
					state_nx = ST_LOC;
				end
			end
			ST_LOC: begin
				cmd.loc_step = 1'b1;
				if (sts.loc_last) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_nx = sts.full ? ST_RESP : ST_INSERT;
			end
			ST_INSERT: begin
				cmd.ins_write = 1'b1;
				state_nx = ST_LINK;
			end
			ST_LINK: begin
				cmd.ins_link = 1'b1;
				state_nx = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
